// File: src/afs_pkg.sv
// Shared types and constants for the animation frame sequencer.
// No dependencies; every other source file but afs_dur_mem refers to it by scoped names.
package afs_pkg;

    localparam int KIND_W   = 2;
    localparam int AMOUNT_W = 20;
    localparam int TIME_W   = 24;
    localparam int INDEX_W  = 4;
    // Shared subtractor width: one bit above the time range.
    localparam int SUB_W    = TIME_W + 1;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_PUSH    = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_RESTART = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FIND,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             borrow;
        logic [SUB_W-1:0] diff;
    } sub_res_t;

endpackage

// File: src/afs_if.sv
// Channel interfaces: item input, result output and the loop configuration write.
// Depends on afs_pkg for field widths.
interface afs_in_if;
    logic                          valid;
    logic                          ready;
    logic [afs_pkg::KIND_W-1:0]    kind;
    logic [afs_pkg::AMOUNT_W-1:0]  amount;

    modport source (output valid, output kind, output amount, input ready);
    modport sink   (input valid, input kind, input amount, output ready);
endinterface

interface afs_out_if;
    logic                         valid;
    logic                         ready;
    logic [afs_pkg::INDEX_W-1:0]  frame_index;
    logic                         frame_valid;
    logic [afs_pkg::TIME_W-1:0]   elapsed_time;
    logic                         table_full;

    modport source (output valid, output frame_index, output frame_valid,
                    output elapsed_time, output table_full, input ready);
    modport sink   (input valid, input frame_index, input frame_valid,
                    input elapsed_time, input table_full, output ready);
endinterface

interface afs_cfg_if;
    logic valid;
    logic ready;
    logic loop_enable;

    modport source (output valid, output loop_enable, input ready);
    modport sink   (input valid, input loop_enable, output ready);
endinterface

// File: src/afs_sub.sv
// Shared subtract-and-compare unit used by the wrap divider and the frame walk.
// Depends on afs_pkg.
module afs_sub
(
    input  logic [afs_pkg::SUB_W-1:0] a,
    input  logic [afs_pkg::SUB_W-1:0] b,
    output afs_pkg::sub_res_t         res
);

    logic [afs_pkg::SUB_W:0] full_diff;

    assign full_diff  = {1'b0, a} - {1'b0, b};
    assign res.borrow = full_diff[afs_pkg::SUB_W];
    assign res.diff   = full_diff[afs_pkg::SUB_W-1:0];

endmodule

// File: src/afs_dur_mem.sv
// Frame duration store: one write port, one read port with registered data.
// No dependencies.
module afs_dur_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 20
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/afs_seq.sv
// Sequencer and datapath registers: executes one item, runs the wrap
// division and the frame walk on the shared subtractor.
// Depends on afs_pkg and afs_if; drives afs_sub and afs_dur_mem.
module afs_seq #(
    parameter int MAX_FRAMES    = 16,
    parameter int DURATION_BITS = 20
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      loop_enable,
    afs_in_if.sink                    item,
    afs_out_if.source                 result,
    output logic [afs_pkg::SUB_W-1:0] sub_a,
    output logic [afs_pkg::SUB_W-1:0] sub_b,
    input  afs_pkg::sub_res_t         sub_res,
    output logic                      mem_we,
    output logic [(MAX_FRAMES > 1 ? $clog2(MAX_FRAMES) : 1)-1:0] mem_waddr,
    output logic [(DURATION_BITS < afs_pkg::AMOUNT_W ? DURATION_BITS
                                                     : afs_pkg::AMOUNT_W)-1:0] mem_wdata,
    output logic [(MAX_FRAMES > 1 ? $clog2(MAX_FRAMES) : 1)-1:0] mem_raddr,
    input  logic [(DURATION_BITS < afs_pkg::AMOUNT_W ? DURATION_BITS
                                                     : afs_pkg::AMOUNT_W)-1:0] mem_rdata
);

    localparam int AMT_W = (DURATION_BITS < afs_pkg::AMOUNT_W) ? DURATION_BITS
                                                               : afs_pkg::AMOUNT_W;
    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int TW    = afs_pkg::TIME_W;
    localparam int SW    = afs_pkg::SUB_W;
    localparam int DIV_STEPS = SW;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_FRAMES);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_STEPS - 1);

    afs_pkg::state_t state_reg, state_next;
    afs_pkg::kind_t  kind_reg, kind_next;
    logic [AMT_W-1:0]  amt_reg, amt_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TW-1:0]     total_reg, total_next;
    logic [TW-1:0]     elapsed_reg, elapsed_next;
    logic [SW-1:0]     dvd_reg, dvd_next;
    logic [TW-1:0]     rem_reg, rem_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              hit_reg, hit_next;
    logic              full_reg, full_next;

    logic                         out_valid_reg, out_valid_next;
    logic [afs_pkg::INDEX_W-1:0]  out_index_reg, out_index_next;
    logic                         out_fvalid_reg, out_fvalid_next;
    logic [TW-1:0]                out_elapsed_reg, out_elapsed_next;
    logic                         out_full_reg, out_full_next;

    logic [SW-1:0]    amt_ext;
    logic [SW-1:0]    tick_sum;
    logic [SW-1:0]    push_sum;
    logic [CNT_W-1:0] last_idx;
    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0] idx_inc;
    logic [IDX_W+afs_pkg::INDEX_W-1:0] idx_wide;
    logic [TW-1:0]    div_rem;
    logic             out_free;

    assign amt_ext  = SW'(amt_reg);
    assign tick_sum = {1'b0, elapsed_reg} + amt_ext;
    assign push_sum = {1'b0, total_reg} + amt_ext;
    assign last_idx = count_reg - 1'b1;
    assign idx_ext  = CNT_W'(idx_reg);
    assign idx_inc  = idx_ext + 1'b1;
    assign idx_wide = {{afs_pkg::INDEX_W{1'b0}}, idx_reg};
    assign out_free = !out_valid_reg || result.ready;
    // Restoring step: keep the difference unless it borrowed.
    assign div_rem  = sub_res.borrow ? sub_a[TW-1:0] : sub_res.diff[TW-1:0];

    assign item.ready = (state_reg == afs_pkg::ST_IDLE);

    // Shared unit operands
    always_comb
    begin
        if (state_reg == afs_pkg::ST_WALK)
        begin
            sub_a = {1'b0, rem_reg};
            sub_b = SW'(mem_rdata);
        end
        else
        begin
            sub_a = {rem_reg, dvd_reg[SW-1]};
            sub_b = {1'b0, total_reg};
        end
    end

    // Read one frame ahead of the walk index
    always_comb
    begin
        if (state_reg == afs_pkg::ST_WALK && idx_inc != CNT_FULL)
        begin
            mem_raddr = idx_inc[IDX_W-1:0];
        end
        else
        begin
            mem_raddr = '0;
        end
    end

    assign mem_waddr = count_reg[IDX_W-1:0];
    assign mem_wdata = amt_reg;

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        amt_next         = amt_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        elapsed_next     = elapsed_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        dcnt_next        = dcnt_reg;
        idx_next         = idx_reg;
        hit_next         = hit_reg;
        full_next        = full_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_index_next   = out_index_reg;
        out_fvalid_next  = out_fvalid_reg;
        out_elapsed_next = out_elapsed_reg;
        out_full_next    = out_full_reg;
        mem_we           = 1'b0;

        unique case (state_reg)
            afs_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    kind_next  = afs_pkg::kind_t'(item.kind);
                    amt_next   = item.amount[AMT_W-1:0];
                    full_next  = 1'b0;
                    hit_next   = 1'b0;
                    idx_next   = '0;
                    state_next = afs_pkg::ST_EXEC;
                end
            end

            afs_pkg::ST_EXEC:
            begin
                state_next = afs_pkg::ST_FIND;
                unique case (kind_reg)
                    afs_pkg::KIND_TICK:
                    begin
                        if (total_reg == '0)
                        begin
                            elapsed_next = '0;
                        end
                        else if (tick_sum > {1'b0, total_reg})
                        begin
                            if (loop_enable)
                            begin
                                // Wrap into [1, total]: ((e - 1) mod total) + 1
                                dvd_next   = tick_sum - 1'b1;
                                rem_next   = '0;
                                dcnt_next  = '0;
                                state_next = afs_pkg::ST_DIV;
                            end
                            else
                            begin
                                elapsed_next = total_reg;
                            end
                        end
                        else
                        begin
                            elapsed_next = tick_sum[TW-1:0];
                        end
                    end
                    afs_pkg::KIND_PUSH:
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                            total_next = push_sum[TW] ? afs_pkg::TIME_MAX : push_sum[TW-1:0];
                        end
                    end
                    afs_pkg::KIND_CLEAR:
                    begin
                        count_next = '0;
                        total_next = '0;
                    end
                    afs_pkg::KIND_RESTART:
                    begin
                        elapsed_next = '0;
                    end
                endcase
            end

            afs_pkg::ST_DIV:
            begin
                rem_next = div_rem;
                dvd_next = {dvd_reg[SW-2:0], 1'b0};
                if (dcnt_reg == DCNT_LAST)
                begin
                    elapsed_next = div_rem + 1'b1;
                    state_next   = afs_pkg::ST_FIND;
                end
                else
                begin
                    dcnt_next = dcnt_reg + 1'b1;
                end
            end

            afs_pkg::ST_FIND:
            begin
                if (count_reg == '0 || elapsed_reg > total_reg)
                begin
                    state_next = afs_pkg::ST_DONE;
                end
                else if (total_reg != '0 && elapsed_reg == total_reg)
                begin
                    // End time belongs to the last frame
                    idx_next   = last_idx[IDX_W-1:0];
                    hit_next   = 1'b1;
                    state_next = afs_pkg::ST_DONE;
                end
                else
                begin
                    rem_next   = elapsed_reg;
                    idx_next   = '0;
                    state_next = afs_pkg::ST_WALK;
                end
            end

            afs_pkg::ST_WALK:
            begin
                // Time left inside this frame's span: stop here
                if (sub_res.borrow)
                begin
                    hit_next   = 1'b1;
                    state_next = afs_pkg::ST_DONE;
                end
                else if (idx_ext == last_idx)
                begin
                    state_next = afs_pkg::ST_DONE;
                end
                else
                begin
                    rem_next = sub_res.diff[TW-1:0];
                    idx_next = idx_inc[IDX_W-1:0];
                end
            end

            afs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_index_next   = hit_reg ? idx_wide[afs_pkg::INDEX_W-1:0] : '0;
                    out_fvalid_next  = hit_reg;
                    out_elapsed_next = elapsed_reg;
                    out_full_next    = full_reg;
                    state_next       = afs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = afs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= afs_pkg::ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        amt_reg         <= amt_next;
        dvd_reg         <= dvd_next;
        rem_reg         <= rem_next;
        dcnt_reg        <= dcnt_next;
        idx_reg         <= idx_next;
        hit_reg         <= hit_next;
        full_reg        <= full_next;
        out_index_reg   <= out_index_next;
        out_fvalid_reg  <= out_fvalid_next;
        out_elapsed_reg <= out_elapsed_next;
        out_full_reg    <= out_full_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.frame_index  = out_index_reg;
    assign result.frame_valid  = out_fvalid_reg;
    assign result.elapsed_time = out_elapsed_reg;
    assign result.table_full   = out_full_reg;

endmodule

// File: src/animation_frame_sequencer_top.sv
// Top level of the animation frame sequencer.
// Depends on afs_pkg, afs_if, afs_sub, afs_dur_mem and afs_seq.
//
// Usage:
//   item   - one transfer per item: kind (tick, push, clear, restart) and amount.
//   result - one transfer per item: frame_index, frame_valid, elapsed_time,
//            table_full, in item order.
//   cfg    - loop_enable write, always ready; write it only while no item is
//            in flight.
// Timing: an item is worked on alone; item.ready is high only between items.
//   After acceptance the item runs EXEC, FIND, the walk and DONE; the walk
//   visits 0 to MAX_FRAMES frames, one frame a cycle through the shared
//   subtractor. A tick that wraps also runs the restoring division on the
//   same subtractor, between EXEC and FIND. The next item can be taken once
//   the result is loaded.
// Stall: a result waits in the output register; the next item is accepted
//   meanwhile and its result is held until the register frees.
// Reset: frame count, total and elapsed time clear, loop_enable sets to 1.
//   Table contents are not cleared; only written entries are ever used.
module animation_frame_sequencer_top #(
    parameter int MAX_FRAMES    = 16,
    parameter int DURATION_BITS = 20
)
(
    input  logic       clk,
    input  logic       rst_n,
    afs_in_if.sink     item,
    afs_out_if.source  result,
    afs_cfg_if.sink    cfg
);

    localparam int AMT_W = (DURATION_BITS < afs_pkg::AMOUNT_W) ? DURATION_BITS
                                                               : afs_pkg::AMOUNT_W;
    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic                      loop_reg;
    logic                      loop_next;
    logic [afs_pkg::SUB_W-1:0] sub_a;
    logic [afs_pkg::SUB_W-1:0] sub_b;
    afs_pkg::sub_res_t         sub_res;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic [AMT_W-1:0]          mem_wdata;
    logic [IDX_W-1:0]          mem_raddr;
    logic [AMT_W-1:0]          mem_rdata;

    assign cfg.ready = 1'b1;
    assign loop_next = cfg.valid ? cfg.loop_enable : loop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_reg <= 1'b1;
        end
        else
        begin
            loop_reg <= loop_next;
        end
    end

    afs_seq #(
        .MAX_FRAMES    (MAX_FRAMES),
        .DURATION_BITS (DURATION_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .loop_enable (loop_reg),
        .item        (item),
        .result      (result),
        .sub_a       (sub_a),
        .sub_b       (sub_b),
        .sub_res     (sub_res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    afs_sub u_sub (
        .a   (sub_a),
        .b   (sub_b),
        .res (sub_res)
    );

    afs_dur_mem #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (AMT_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// File: src/afs_chk.sv
// Port-level checks on the animation frame sequencer, bound to the top level.
// Depends on afs_pkg and animation_frame_sequencer_top.
module afs_chk
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [afs_pkg::INDEX_W-1:0]  frame_index,
    input logic                         frame_valid,
    input logic [afs_pkg::TIME_W-1:0]   elapsed_time,
    input logic                         table_full
);

    // An item is worked on alone: no transfer right after one
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted on consecutive cycles");

    // No frame means index zero
    a_index_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !frame_valid |-> frame_index == '0)
        else $error("frame_index nonzero without a valid frame");

    // Hold a stalled result steady until its transfer
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(frame_index)
            && $stable(frame_valid) && $stable(elapsed_time) && $stable(table_full))
        else $error("stalled result changed");

endmodule

bind animation_frame_sequencer_top afs_chk u_afs_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .frame_index  (result.frame_index),
    .frame_valid  (result.frame_valid),
    .elapsed_time (result.elapsed_time),
    .table_full   (result.table_full)
);

// File: tb/tb_top.sv
// Self-checking testbench for the animation frame sequencer top level.
// Depends on afs_pkg, the channel interfaces in afs_if and the top level; predicts every result in-line.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES = 16;
    localparam int AMT_W  = afs_pkg::AMOUNT_W;
    localparam int IDX_W  = afs_pkg::INDEX_W;

    typedef struct packed {
        afs_pkg::kind_t                kind;
        logic [afs_pkg::AMOUNT_W-1:0]  amount;
    } frame_cmd_t;

    typedef struct packed {
        logic [afs_pkg::INDEX_W-1:0]  frame_index;
        logic                         frame_valid;
        logic [afs_pkg::TIME_W-1:0]   elapsed_time;
        logic                         table_full;
    } frame_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    afs_in_if  item_ch ();
    afs_out_if result_ch ();
    afs_cfg_if cfg_ch ();

    animation_frame_sequencer_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    // Timeline state as the block should hold it
    logic [afs_pkg::AMOUNT_W-1:0] dur_tab [FRAMES];
    logic [4:0]                   frame_cnt = '0;
    logic [afs_pkg::TIME_W-1:0]   total_acc = '0;
    logic [afs_pkg::TIME_W-1:0]   elapsed_acc = '0;
    logic                         loop_on = 1'b1;

    frame_cmd_t    pending_cmds [$];
    frame_report_t expected_frames [$];

    int mismatches = 0;
    int items_taken;
    int tx_burst_left;
    int tx_gap_left;

    logic [31:0] rx_cycle;
    logic [1:0]  rx_mode;
    int          hold_left;
    logic        hold_done;

    function automatic frame_report_t advance_timeline(input afs_pkg::kind_t kind,
                                                       input logic [afs_pkg::AMOUNT_W-1:0] amount);
        frame_report_t              rep;
        logic [afs_pkg::TIME_W:0]   sum;
        logic [afs_pkg::TIME_W+1:0] start;
        logic [afs_pkg::TIME_W+1:0] stop;
        int                         i;
        rep = '0;
        case (kind)
            afs_pkg::KIND_TICK:
            begin
                sum = {1'b0, elapsed_acc} + amount;
                if (total_acc == '0)
                    sum = '0;
                else if (sum > {1'b0, total_acc})
                    sum = loop_on ? ((sum - 1'b1) % {1'b0, total_acc}) + 1'b1
                                  : {1'b0, total_acc};
                elapsed_acc = sum[afs_pkg::TIME_W-1:0];
            end
            afs_pkg::KIND_PUSH:
            begin
                if (frame_cnt == FRAMES)
                    rep.table_full = 1'b1;
                else
                begin
                    dur_tab[frame_cnt[3:0]] = amount;
                    frame_cnt = frame_cnt + 1'b1;
                    sum = {1'b0, total_acc} + amount;
                    total_acc = (sum > afs_pkg::TIME_MAX) ? afs_pkg::TIME_MAX
                                                          : sum[afs_pkg::TIME_W-1:0];
                end
            end
            afs_pkg::KIND_CLEAR:
            begin
                frame_cnt = '0;
                total_acc = '0;
            end
            default:
                elapsed_acc = '0;
        endcase

        rep.elapsed_time = elapsed_acc;
        if (frame_cnt != 0 && elapsed_acc <= total_acc)
        begin
            // The end time picks the last frame, even a zero-length one
            if (total_acc != '0 && elapsed_acc == total_acc)
            begin
                rep.frame_index = IDX_W'(frame_cnt - 1);
                rep.frame_valid = 1'b1;
            end
            else
            begin
                start = '0;
                for (i = 0; i < frame_cnt; i++)
                begin
                    stop = start + dur_tab[i];
                    if (!rep.frame_valid && elapsed_acc >= start && elapsed_acc < stop)
                    begin
                        rep.frame_index = IDX_W'(i);
                        rep.frame_valid = 1'b1;
                    end
                    start = stop;
                end
            end
        end
        return rep;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    task automatic push_cmd(input afs_pkg::kind_t kind,
                            input logic [afs_pkg::AMOUNT_W-1:0] amount);
        frame_cmd_t cmd;
        cmd.kind   = kind;
        cmd.amount = amount;
        pending_cmds.insert(pending_cmds.size(), cmd);
    endtask

    function automatic logic [afs_pkg::AMOUNT_W-1:0] frame_len();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return AMT_W'($urandom_range(0, 20'hFFFFF));
            default: return AMT_W'($urandom_range(1, 30));
        endcase
    endfunction

    function automatic logic [afs_pkg::AMOUNT_W-1:0] step_len();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return AMT_W'($urandom_range(0, 20'hFFFFF));
            2: return AMT_W'($urandom_range(20, 200));
            default: return AMT_W'($urandom_range(1, 25));
        endcase
    endfunction

    function automatic logic [afs_pkg::AMOUNT_W-1:0] long_len();
        return AMT_W'($urandom_range(20'h80000, 20'hFFFFF));
    endfunction

    // Mostly well-formed episodes: usually a clear, build a table, then run time over it
    task automatic queue_random(input int n);
        int goal;
        int nf;
        int nt;
        bit heavy;
        goal = pending_cmds.size() + n;
        while (pending_cmds.size() < goal)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(2, 6))
                    push_cmd(afs_pkg::kind_t'($urandom_range(0, 3)), AMT_W'($urandom()));
            end
            else
            begin
                heavy = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 4) != 0)
                    push_cmd(afs_pkg::KIND_CLEAR, AMT_W'($urandom()));
                nf = ($urandom_range(0, 3) == 0) ? int'($urandom_range(9, 18))
                                                 : int'($urandom_range(1, 8));
                repeat (nf)
                    push_cmd(afs_pkg::KIND_PUSH, heavy ? long_len() : frame_len());
                if ($urandom_range(0, 3) == 0)
                    push_cmd(afs_pkg::KIND_RESTART, AMT_W'($urandom()));
                nt = int'($urandom_range(4, 20));
                repeat (nt)
                begin
                    case ($urandom_range(0, 19))
                        0: push_cmd(afs_pkg::KIND_RESTART, AMT_W'($urandom()));
                        1: push_cmd(afs_pkg::KIND_PUSH, frame_len());
                        2: push_cmd(afs_pkg::KIND_CLEAR, AMT_W'($urandom()));
                        default: push_cmd(afs_pkg::KIND_TICK, heavy ? long_len() : step_len());
                    endcase
                end
            end
        end
    endtask

    // Hold until every queued item went in and every result came back
    task automatic drain();
        @(negedge clk);
        while (pending_cmds.size() != 0 || item_ch.valid || expected_frames.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_loop(input logic on);
        @(posedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.loop_enable <= on;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        loop_on = on;
    endtask

    // Item driver: bursts of random length with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin : driver
        frame_cmd_t nxt;
        if (!rst_n)
        begin
            item_ch.valid  <= 1'b0;
            item_ch.kind   <= afs_pkg::KIND_TICK;
            item_ch.amount <= '0;
            items_taken    <= 0;
            tx_burst_left  <= 0;
            tx_gap_left    <= 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                expected_frames.insert(expected_frames.size(),
                                       advance_timeline(afs_pkg::kind_t'(item_ch.kind),
                                                        item_ch.amount));
                items_taken <= items_taken + 1;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (tx_gap_left != 0)
                begin
                    item_ch.valid <= 1'b0;
                    tx_gap_left   <= tx_gap_left - 1;
                end
                else if (pending_cmds.size() != 0)
                begin
                    nxt = pending_cmds.pop_front();
                    item_ch.valid  <= 1'b1;
                    item_ch.kind   <= nxt.kind;
                    item_ch.amount <= nxt.amount;
                    if (tx_burst_left <= 1)
                    begin
                        tx_burst_left <= int'($urandom_range(1, 12));
                        tx_gap_left   <= ($urandom_range(0, 3) == 0) ? 0
                                                                     : int'($urandom_range(1, 10));
                    end
                    else
                        tx_burst_left <= tx_burst_left - 1;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Result ready: a randomly re-picked pattern, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            rx_cycle        <= '0;
            rx_mode         <= '0;
            hold_left       <= 0;
            hold_done       <= 1'b0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle[5:0] == 6'd63)
                rx_mode <= 2'($urandom_range(0, 3));
            if (hold_left != 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left       <= hold_left - 1;
            end
            else if (!hold_done && items_taken >= 250)
            begin
                result_ch.ready <= 1'b0;
                hold_left       <= 400;
                hold_done       <= 1'b1;
            end
            else
            begin
                case (rx_mode)
                    2'd0: result_ch.ready <= 1'b1;
                    2'd1: result_ch.ready <= 1'($urandom_range(0, 1));
                    2'd2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= (rx_cycle[2:0] != 3'd0);
                endcase
            end
        end
    end

    // Result monitor: compare each transfer with the oldest prediction
    always @(posedge clk)
    begin : monitor
        frame_report_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_frames.size() == 0)
                flag_mismatch("unexpected result, elapsed_time", '0,
                              32'(result_ch.elapsed_time));
            else
            begin
                want = expected_frames.pop_front();
                if (result_ch.frame_index !== want.frame_index)
                    flag_mismatch("frame_index", 32'(want.frame_index),
                                  32'(result_ch.frame_index));
                if (result_ch.frame_valid !== want.frame_valid)
                    flag_mismatch("frame_valid", 32'(want.frame_valid),
                                  32'(result_ch.frame_valid));
                if (result_ch.elapsed_time !== want.elapsed_time)
                    flag_mismatch("elapsed_time", 32'(want.elapsed_time),
                                  32'(result_ch.elapsed_time));
                if (result_ch.table_full !== want.table_full)
                    flag_mismatch("table_full", 32'(want.table_full),
                                  32'(result_ch.table_full));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        cfg_ch.valid       = 1'b0;
        cfg_ch.loop_enable = 1'b1;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: loop_enable left at its reset value
        push_cmd(afs_pkg::KIND_TICK, 20'd5);       // zero total holds time at zero
        push_cmd(afs_pkg::KIND_PUSH, 20'd0);       // zero-length frame
        push_cmd(afs_pkg::KIND_PUSH, 20'd10);
        push_cmd(afs_pkg::KIND_TICK, 20'd10);      // lands on the end time
        push_cmd(afs_pkg::KIND_TICK, 20'd1);       // wraps to one
        push_cmd(afs_pkg::KIND_TICK, 20'd19);      // exact multiple lands on the total
        push_cmd(afs_pkg::KIND_CLEAR, 20'hFFFFF);
        push_cmd(afs_pkg::KIND_PUSH, 20'd5);       // elapsed now beyond the total
        push_cmd(afs_pkg::KIND_TICK, 20'd0);
        push_cmd(afs_pkg::KIND_RESTART, 20'hFFFFF);
        repeat (FRAMES - 1)
            push_cmd(afs_pkg::KIND_PUSH, 20'hFFFFF);
        push_cmd(afs_pkg::KIND_PUSH, 20'd1);       // dropped: table is full
        push_cmd(afs_pkg::KIND_TICK, 20'hFFFFF);
        drain();

        set_loop(1'b0);
        queue_random(150);
        drain();
        set_loop(1'b1);
        queue_random(300);
        drain();
        set_loop(1'b0);
        queue_random(120);
        drain();
        set_loop(1'b1);
        queue_random(30);
        drain();

        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: animation_frame_sequencer_top.f
src/afs_pkg.sv
src/afs_if.sv
src/afs_sub.sv
src/afs_dur_mem.sv
src/afs_seq.sv
src/animation_frame_sequencer_top.sv
src/afs_chk.sv
tb/tb_top.sv
